// ===== design/mip_level_select_top_macros.svh =====
// assertion macros shared by the mip level select design
// depends on nothing; files that assert include it by bare name
`ifndef MIP_LEVEL_SELECT_TOP_MACROS_SVH
`define MIP_LEVEL_SELECT_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MLS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mls_pkg.sv =====
// shared types and constants for the mip level select block
// depends on nothing; used by mls_lod_calc and mip_level_select_top
package mls_pkg;

    localparam int unsigned MAX_LEVELS = 15;

    localparam int unsigned LOD_W   = 32;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned FRAC_W  = 6;
    localparam int unsigned ERR_W   = 2;
    localparam int unsigned FIXED_W = LEVEL_W + FRAC_W;

    // binary32 pattern of 1/128 with the sign bit dropped
    localparam logic [30:0] LOD_MIN_MAG = 31'h3C00_0000;
    // biased exponent at which value*64 is an integer count of the mantissa
    localparam logic [7:0]  EXP_SAT     = 8'd131;
    localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
    localparam logic [FRAC_W-1:0] FRAC_HALF = FRAC_W'(32);

    typedef enum logic [MODE_W-1:0] {
        FILT_NONE    = 2'd0,
        FILT_NEAREST = 2'd1,
        FILT_LINEAR  = 2'd2,
        FILT_UNKNOWN = 2'd3
    } filter_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_BAD_LOD    = 2'd1,
        ERR_BAD_FILTER = 2'd2
    } err_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] first_level;
        logic [LEVEL_W-1:0] second_level;
        logic [FRAC_W-1:0]  blend_weight;
        err_t               error_code;
    } result_t;

endpackage

// ===== design/mip_level_select_top.sv =====
// out_valid rises once the input transaction has passed the input reg, then the result reg
// throughput: one transaction per cycle unless out_ready stalls; the only loop is the two-entry register pipe
// backpressure on out_ready stalls the pipe; both stages fill before in_ready drops
// reset (rst_n, async active low) empties both stages; payload registers are not reset
// top level of mip level select; depends on mls_pkg, mls_lod_calc
// assertion macros from mip_level_select_top_macros.svh
module mip_level_select_top #(
    parameter int unsigned MAX_LEVELS = mls_pkg::MAX_LEVELS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mls_pkg::LOD_W-1:0]    lod_bits,
    input  logic [mls_pkg::COUNT_W-1:0]  num_levels,
    input  logic [mls_pkg::MODE_W-1:0]   filter_mode,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mls_pkg::LEVEL_W-1:0]  first_level,
    output logic [mls_pkg::LEVEL_W-1:0]  second_level,
    output logic [mls_pkg::FRAC_W-1:0]   blend_weight,
    output logic [mls_pkg::ERR_W-1:0]    error_code
);
    import mls_pkg::*;

    // input stage
    logic                 in_valid_reg;
    logic [LOD_W-1:0]     lod_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [MODE_W-1:0]    mode_reg;

    // result stage
    logic                 res_valid_reg;
    result_t              res_reg;
    result_t              res_next;

    logic                 res_load;
    logic                 in_load;

    // result stage takes a new value when it is empty or being drained
    assign res_load = !res_valid_reg || out_ready;
    // input stage can take a transaction when empty or when it moves forward
    assign in_ready = !in_valid_reg || res_load;
    assign in_load  = in_valid && in_ready;

    mls_lod_calc #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_calc (
        .lod_bits    (lod_reg),
        .num_levels  (count_reg),
        .filter_mode (mode_reg),
        .result      (res_next)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (res_load)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            lod_reg   <= lod_bits;
            count_reg <= num_levels;
            mode_reg  <= filter_mode;
        end
        if (res_load && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign first_level  = res_reg.first_level;
    assign second_level = res_reg.second_level;
    assign blend_weight = res_reg.blend_weight;
    assign error_code   = res_reg.error_code;

`include "mip_level_select_top_macros.svh"

    // any error zeroes the level pair and weight
    `MLS_ASSERT_IMPL(a_err_zero, clk, rst_n,
        out_valid && (res_reg.error_code != ERR_NONE),
        (first_level == '0) && (second_level == '0) && (blend_weight == '0),
        "error result carries nonzero levels or weight")

    // second level never below first, weight only with distinct levels
    `MLS_ASSERT_IMPL(a_level_order, clk, rst_n,
        out_valid,
        (second_level >= first_level)
            && ((blend_weight == '0) || (second_level != first_level)),
        "level pair or weight inconsistent")

    // in_ready only drops with both stages full and output stalled
    `MLS_ASSERT_IMPL(a_ready_full, clk, rst_n,
        !in_ready,
        in_valid_reg && res_valid_reg && !out_ready,
        "in_ready low while pipe can move")

    // an item in the input stage reaches the output when the pipe moves
    `MLS_ASSERT_NEXT(a_advance, clk, rst_n,
        in_valid_reg && res_load,
        out_valid,
        "input stage item lost on advance")

endmodule

// ===== design/mls_lod_calc.sv =====
// combinational lod to mip level pair and blend weight
// depends on mls_pkg
module mls_lod_calc #(
    parameter int unsigned MAX_LEVELS = mls_pkg::MAX_LEVELS
) (
    input  logic [mls_pkg::LOD_W-1:0]   lod_bits,
    input  logic [mls_pkg::COUNT_W-1:0] num_levels,
    input  logic [mls_pkg::MODE_W-1:0]  filter_mode,
    output mls_pkg::result_t            result
);
    import mls_pkg::*;

    logic                 bad_lod;
    logic [COUNT_W-1:0]   top;
    logic [FIXED_W-1:0]   top_fixed;
    logic [31:0]          round_sum;
    logic [7:0]           r_exp;
    logic [10:0]          r_mant;
    logic [7:0]           shift_full;
    logic [FIXED_W-1:0]   shifted;
    logic                 to_zero;
    logic                 saturate;
    logic [FIXED_W-1:0]   fixed;
    logic [LEVEL_W-1:0]   first_raw;
    logic [FRAC_W-1:0]    frac;
    logic [LEVEL_W-1:0]   near_level;
    logic [LEVEL_W-1:0]   next_level;

    assign bad_lod = (lod_bits[30:23] == EXP_ALL_ONES) || (num_levels == '0)
                   || (32'(num_levels) > MAX_LEVELS);

    assign top       = num_levels - COUNT_W'(1);
    assign top_fixed = {top, FRAC_W'(0)};

    // round magnitude to binary16 precision, ties to even
    assign round_sum  = {1'b0, lod_bits[30:0]} + 32'h0000_0FFF + {31'b0, lod_bits[13]};
    assign r_exp      = round_sum[30:23];
    assign r_mant     = {1'b1, round_sum[22:13]};
    assign shift_full = EXP_SAT - r_exp;
    // shift is at least one whenever the value is used, so the top bit drops out
    assign shifted    = FIXED_W'(r_mant >> shift_full[3:0]);

    assign to_zero  = lod_bits[31] || (lod_bits[30:0] < LOD_MIN_MAG) || (top == '0);
    assign saturate = (r_exp >= EXP_SAT);

    always_comb
    begin
        priority if (to_zero)
        begin
            fixed = '0;
        end
        else if (saturate)
        begin
            fixed = top_fixed;
        end
        else if (shifted > top_fixed)
        begin
            fixed = top_fixed;
        end
        else
        begin
            fixed = shifted;
        end
    end

    assign first_raw = fixed[FIXED_W-1:FRAC_W];
    assign frac      = fixed[FRAC_W-1:0];

    // at the top level frac is zero, so neither step can pass top
    assign next_level = (first_raw < top) ? first_raw + LEVEL_W'(1) : top;
    assign near_level = (frac > FRAC_HALF) ? next_level : first_raw;

    always_comb
    begin
        result = '{first_level: '0, second_level: '0, blend_weight: '0,
                   error_code: ERR_NONE};
        if (bad_lod)
        begin
            result.error_code = ERR_BAD_LOD;
        end
        else
        begin
            unique case (filter_t'(filter_mode))
                FILT_NONE:
                begin
                    result.error_code = ERR_NONE;
                end
                FILT_NEAREST:
                begin
                    result.first_level  = near_level;
                    result.second_level = near_level;
                end
                FILT_LINEAR:
                begin
                    result.first_level  = first_raw;
                    result.second_level = next_level;
                    result.blend_weight = frac;
                end
                FILT_UNKNOWN:
                begin
                    result.error_code = ERR_BAD_FILTER;
                end
                default:
                begin
                    result.error_code = ERR_BAD_FILTER;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb_mip_level_select_top.sv =====
// self-checking testbench for mip_level_select_top: directed table, then random lod requests
// depends on mls_pkg and the mip_level_select_top rtl; expected selections are predicted locally
`timescale 1ns / 1ps

module tb_mip_level_select_top;
    import mls_pkg::*;

    localparam int N_DIR       = 24;
    localparam int N_RAND      = 1800;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_TAIL  = 8;

    // one row of the directed table; want is only used when typed is set
    typedef struct packed {
        logic [LOD_W-1:0]   lod;
        logic [COUNT_W-1:0] cnt;
        filter_t            mode;
        logic               typed;
        result_t            want;
    } sel_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [LOD_W-1:0]    lod_bits;
    logic [COUNT_W-1:0]  num_levels;
    logic [MODE_W-1:0]   filter_mode;
    logic                out_valid;
    logic                out_ready;
    logic [LEVEL_W-1:0]  first_level;
    logic [LEVEL_W-1:0]  second_level;
    logic [FRAC_W-1:0]   blend_weight;
    logic [ERR_W-1:0]    error_code;

    // selections still owed by the block, oldest first
    result_t  pending_sel[$];
    sel_row_t dir_rows [0:N_DIR-1];
    int       mismatch_cnt;
    int       in_calm;
    int       out_calm;
    logic     stim_done;

    mip_level_select_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .lod_bits     (lod_bits),
        .num_levels   (num_levels),
        .filter_mode  (filter_mode),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_level  (first_level),
        .second_level (second_level),
        .blend_weight (blend_weight),
        .error_code   (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // clamped lod in 1/64 units: sub-1/128 flushes to zero, otherwise round to
    // half precision (ties to even) and truncate to six fraction bits
    function automatic int unsigned lod_sixty_fourths(logic [31:0] bits, int unsigned top);
        logic [31:0]  mag;
        logic [31:0]  rnd;
        int unsigned  expo;
        int unsigned  ipart;
        int unsigned  mant;
        int unsigned  sh;
        int unsigned  fx;
        if (bits[31])
            return 0;                   // negative values and negative zero
        mag = {1'b0, bits[30:0]};
        if (mag < 32'h3C00_0000)
            return 0;
        if (top == 0)
            return 0;
        if (mag >= 32'h3F80_0000)
        begin
            expo = 32'(mag[30:23]);
            if (expo >= 131)
                return top << 6;
            ipart = 32'({1'b1, mag[22:0]}) >> (150 - expo);
            if (ipart >= top)
                return top << 6;
        end
        rnd  = (mag + 32'h0000_0FFF + {31'd0, mag[13]}) & ~32'h0000_1FFF;
        expo = 32'(rnd[30:23]);
        mant = 32'({1'b1, rnd[22:13]});
        if (expo >= 131)
            return top << 6;
        sh = 131 - expo;
        if (sh > 31)
            return 0;
        fx = mant >> sh;
        if (fx > (top << 6))
            fx = top << 6;
        return fx;
    endfunction

    function automatic result_t select_levels(logic [31:0] bits, logic [3:0] cnt, filter_t mode);
        result_t     r;
        int unsigned top;
        int unsigned fx;
        int unsigned frac;
        int unsigned lvl;
        r = '{4'd0, 4'd0, 6'd0, ERR_NONE};
        if (bits[30:23] == 8'hFF || cnt == 0 || cnt > MAX_LEVELS)
            r.error_code = ERR_BAD_LOD;
        else if (mode == FILT_UNKNOWN)
            r.error_code = ERR_BAD_FILTER;
        else if (mode != FILT_NONE)
        begin
            top  = cnt - 1;
            fx   = lod_sixty_fourths(bits, top);
            frac = fx & 63;
            lvl  = fx >> 6;
            if (mode == FILT_NEAREST)
            begin
                // round up only strictly above one half
                if (frac > 32)
                    lvl = lvl + 1;
                if (lvl > top)
                    lvl = top;
                r.first_level  = lvl[3:0];
                r.second_level = lvl[3:0];
            end
            else
            begin
                r.first_level  = lvl[3:0];
                r.second_level = (lvl + 1 < top) ? 4'(lvl + 1) : 4'(top);
                r.blend_weight = frac[5:0];
            end
        end
        return r;
    endfunction

    // idle length for either side: mostly zero or short, a few long, and now
    // and then a calm stretch with no idling at all
    function automatic int idle_len(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // lod patterns weighted toward the interesting range of the clamp and rounding
    function automatic logic [31:0] pick_lod();
        logic        neg;
        logic [7:0]  expo;
        logic [22:0] man;
        neg  = ($urandom_range(0, 15) == 0);
        man  = 23'($urandom);
        expo = 8'($urandom_range(118, 133));
        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return {neg, 8'hFF, 23'd0};
                    3: return {neg, 8'hFF, man | 23'd1};
                    4: return {neg, 8'h00, man};
                    default: return {neg, 8'hFE, man};
                endcase
            end
            2:
            begin
                // low bits sitting on or next to the half-precision rounding point
                case ($urandom_range(0, 2))
                    0: man[12:0] = 13'h1000;
                    1: man[12:0] = 13'h0FFF;
                    default: man[12:0] = 13'h1001;
                endcase
                return {neg, 8'($urandom_range(120, 130)), man};
            end
            3: return {1'b0, 8'($urandom_range(127, 131)), man[22:17], 17'd0};
            default: return {neg, expo, man};
        endcase
    endfunction

    // drive one request and record what it must produce once it is taken
    task automatic send_request(logic [31:0] lod, logic [3:0] cnt, filter_t mode,
                                logic typed, result_t want);
        int gap;
        gap = idle_len(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        lod_bits    <= lod;
        num_levels  <= cnt;
        filter_mode <= mode;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_sel.push_back(typed ? want : select_levels(lod, cnt, mode));
        @(negedge clk);
    endtask

    // stimulus: reset, directed table, random requests
    initial
    begin
        int i;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        lod_bits    = '0;
        num_levels  = '0;
        filter_mode = '0;
        stim_done   = 1'b0;
        in_calm     = 0;
        mismatch_cnt = 0;

        dir_rows = '{
            // exponent all ones and bad count give the bad-lod code
            '{32'h7FC0_0000, 4'd4,  FILT_LINEAR,  1'b1, '{4'd0, 4'd0, 6'd0, ERR_BAD_LOD}},
            '{32'h7F80_0000, 4'd4,  FILT_NEAREST, 1'b1, '{4'd0, 4'd0, 6'd0, ERR_BAD_LOD}},
            '{32'hFF80_0000, 4'd4,  FILT_NONE,    1'b1, '{4'd0, 4'd0, 6'd0, ERR_BAD_LOD}},
            '{32'hFFFF_FFFF, 4'd15, FILT_LINEAR,  1'b1, '{4'd0, 4'd0, 6'd0, ERR_BAD_LOD}},
            '{32'h3F80_0000, 4'd0,  FILT_LINEAR,  1'b1, '{4'd0, 4'd0, 6'd0, ERR_BAD_LOD}},
            // bad lod wins over unknown filter
            '{32'h7FC0_0000, 4'd4,  FILT_UNKNOWN, 1'b1, '{4'd0, 4'd0, 6'd0, ERR_BAD_LOD}},
            '{32'h3F80_0000, 4'd4,  FILT_UNKNOWN, 1'b1, '{4'd0, 4'd0, 6'd0, ERR_BAD_FILTER}},
            '{32'h0000_0000, 4'd15, FILT_UNKNOWN, 1'b1, '{4'd0, 4'd0, 6'd0, ERR_BAD_FILTER}},
            // filter none ignores the lod
            '{32'h3FC0_0000, 4'd4,  FILT_NONE,    1'b1, '{4'd0, 4'd0, 6'd0, ERR_NONE}},
            // negative zero, negative value, below 1/128, denormal
            '{32'h8000_0000, 4'd4,  FILT_LINEAR,  1'b1, '{4'd0, 4'd1, 6'd0, ERR_NONE}},
            '{32'hBF80_0000, 4'd4,  FILT_NEAREST, 1'b1, '{4'd0, 4'd0, 6'd0, ERR_NONE}},
            '{32'h3BFF_FFFF, 4'd4,  FILT_LINEAR,  1'b1, '{4'd0, 4'd1, 6'd0, ERR_NONE}},
            '{32'h0000_0001, 4'd8,  FILT_LINEAR,  1'b1, '{4'd0, 4'd1, 6'd0, ERR_NONE}},
            '{32'h3C00_0000, 4'd4,  FILT_LINEAR,  1'b0, '0},
            // largest finite lod and exact top level clamp
            '{32'h7F7F_FFFF, 4'd15, FILT_LINEAR,  1'b1, '{4'd14, 4'd14, 6'd0, ERR_NONE}},
            '{32'h4160_0000, 4'd15, FILT_LINEAR,  1'b1, '{4'd14, 4'd14, 6'd0, ERR_NONE}},
            '{32'h40A0_0000, 4'd1,  FILT_NEAREST, 1'b1, '{4'd0, 4'd0, 6'd0, ERR_NONE}},
            '{32'h0000_0000, 4'd1,  FILT_LINEAR,  1'b1, '{4'd0, 4'd0, 6'd0, ERR_NONE}},
            // exactly one half stays down on nearest, just above goes up
            '{32'h3FC0_0000, 4'd4,  FILT_LINEAR,  1'b1, '{4'd1, 4'd2, 6'd32, ERR_NONE}},
            '{32'h3FC0_0000, 4'd4,  FILT_NEAREST, 1'b1, '{4'd1, 4'd1, 6'd0, ERR_NONE}},
            '{32'h3FC2_0000, 4'd4,  FILT_NEAREST, 1'b0, '0},
            '{32'h4079_999A, 4'd4,  FILT_NEAREST, 1'b0, '0},
            // half-precision rounding: tie to even, and a carry into the next level
            '{32'h3F80_1000, 4'd4,  FILT_LINEAR,  1'b0, '0},
            '{32'h3FFF_FFFF, 4'd15, FILT_LINEAR,  1'b0, '0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < N_DIR; i++)
            send_request(dir_rows[i].lod, dir_rows[i].cnt, dir_rows[i].mode,
                         dir_rows[i].typed, dir_rows[i].want);

        for (i = 0; i < N_RAND; i++)
            send_request(pick_lod(), 4'($urandom_range(0, 15)),
                         filter_t'($urandom_range(0, 3)), 1'b0, '0);

        in_valid  <= 1'b0;
        stim_done = 1'b1;
    end

    // result side backpressure
    initial
    begin
        int st;
        out_ready = 1'b0;
        out_calm  = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            st = idle_len(out_calm);
            if (st > 0)
            begin
                out_ready <= 1'b0;
                repeat (st) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
        end
    end

    // compare every result transaction with the oldest pending selection
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_sel.size() == 0)
                begin
                    $error("result transaction with nothing pending: %0d %0d %0d %0d",
                           first_level, second_level, blend_weight, error_code);
                    mismatch_cnt++;
                end
                else
                begin
                    want = pending_sel.pop_front();
                    if (first_level !== want.first_level)
                    begin
                        $error("first_level expected %0d actual %0d",
                               want.first_level, first_level);
                        mismatch_cnt++;
                    end
                    if (second_level !== want.second_level)
                    begin
                        $error("second_level expected %0d actual %0d",
                               want.second_level, second_level);
                        mismatch_cnt++;
                    end
                    if (blend_weight !== want.blend_weight)
                    begin
                        $error("blend_weight expected %0d actual %0d",
                               want.blend_weight, blend_weight);
                        mismatch_cnt++;
                    end
                    if (error_code !== want.error_code)
                    begin
                        $error("error_code expected %0d actual %0d",
                               want.error_code, error_code);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // watchdog: too long with no transaction on either side ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("[mip_level_select_top] ERROR");
                $finish;
            end
        end
    end

    // end of run: drain, let the two-stage pipe settle, then report
    initial
    begin
        wait (stim_done === 1'b1);
        while (pending_sel.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("[mip_level_select_top] OK");
        else
            $display("[mip_level_select_top] ERROR");
        $finish;
    end

endmodule
